@@ rtl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

	localparam int unsigned PRIO_W  = 32;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_TOP    = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2
	} spq_op_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_e;

	typedef struct packed {
		spq_op_e                   opcode;
		logic [DATA_W-1:0]         payload;
		logic signed [PRIO_W-1:0]  priority_req;
	} spq_cmd_t;

	typedef struct packed {
		spq_status_e               status;
		logic                      head_valid;
		logic [DATA_W-1:0]         head_payload;
		logic signed [PRIO_W-1:0]  head_priority;
		logic [COUNT_W-1:0]        entry_count;
	} spq_res_t;

	// Shift controls broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} spq_ctl_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none

module spq_cell import spq_pkg::*; #(
	parameter int unsigned PAYLOAD_BITS = 32,
	parameter bit          HEAD         = 1'b0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire spq_ctl_t                 ctl,
	input  wire logic signed [PRIO_W-1:0] new_prio,
	input  wire logic [PAYLOAD_BITS-1:0]  new_pay,
	input  wire logic                     left_disp,
	input  wire logic                     left_valid,
	input  wire logic signed [PRIO_W-1:0] left_prio,
	input  wire logic [PAYLOAD_BITS-1:0]  left_pay,
	input  wire logic                     right_valid,
	input  wire logic signed [PRIO_W-1:0] right_prio,
	input  wire logic [PAYLOAD_BITS-1:0]  right_pay,
	output logic                          disp,
	output logic                          valid,
	output logic signed [PRIO_W-1:0]      prio,
	output logic [PAYLOAD_BITS-1:0]       pay
);

	logic                      valid_q;
	logic signed [PRIO_W-1:0]  prio_q;
	logic [PAYLOAD_BITS-1:0]   pay_q;
	logic                      beats_me;

	// The head gives way only to a strictly greater priority; later cells
	// give way to anything not strictly below them, so a tie lands in front.
	always_comb begin
		if (HEAD) begin
			beats_me = new_prio > prio_q;
		end else begin
			beats_me = prio_q <= new_prio;
		end
		disp = !valid_q || beats_me;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && disp) begin
			valid_q <= left_disp ? left_valid : 1'b1;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && disp) begin
			// advance the left neighbor's entry, or take the new one here
			prio_q <= left_disp ? left_prio : new_prio;
			pay_q  <= left_disp ? left_pay : new_pay;
		end else if (ctl.pop) begin
			prio_q <= right_prio;
			pay_q  <= right_pay;
		end
	end

	assign valid = valid_q;
	assign prio  = prio_q;
	assign pay   = pay_q;

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue_core.sv @@
`default_nettype none

// Sorted max-priority queue of up to DEPTH entries, built as a chain of cells.
// Cell 0 always holds the head; entries are kept in descending priority.
// Command channel: a beat on cmd is taken at a rising edge with start high and
// busy low. busy stays low, so one command may follow another every cycle.
// Result channel: one beat on res per command, marked by done for one cycle,
// the cycle right after the command is taken (throughput 1/cycle).
// An insert compares the new priority in every cell at once and shifts the
// lower part of the chain one cell toward the tail; a pop shifts the whole
// chain one cell toward the head. Both take effect at the accepting edge.
// An insert into a full queue is dropped with status full; a pop on an empty
// queue changes nothing and reports status empty. A top query only reports.
// Reset clears all valid bits and the entry count; the queue starts empty.
// The receiver cannot hold results off: res is valid only while done is high.
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int unsigned DEPTH        = 16,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire spq_cmd_t cmd,
	output logic          done,
	output spq_res_t      res
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                     accept;
	logic                     full;
	logic                     empty;
	spq_ctl_t                 ctl;
	logic [PAYLOAD_BITS-1:0]  new_pay;
	logic [DEPTH-1:0]         cell_disp;
	logic [DEPTH-1:0]         cell_valid;
	logic signed [PRIO_W-1:0] cell_prio [DEPTH];
	logic [PAYLOAD_BITS-1:0]  cell_pay  [DEPTH];
	logic [CW-1:0]            count_q;
	logic                     done_q;
	spq_status_e              status_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign full    = cell_valid[DEPTH-1];
	assign empty   = !cell_valid[0];
	assign new_pay = PAYLOAD_BITS'(cmd.payload);

	always_comb begin
		ctl.ins = accept && (cmd.opcode == OP_INSERT) && !full;
		ctl.pop = accept && (cmd.opcode == OP_POP) && !empty;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                     l_disp;
			logic                     l_valid;
			logic signed [PRIO_W-1:0] l_prio;
			logic [PAYLOAD_BITS-1:0]  l_pay;
			logic                     r_valid;
			logic signed [PRIO_W-1:0] r_prio;
			logic [PAYLOAD_BITS-1:0]  r_pay;

			if (gi == 0) begin : g_left_end
				assign l_disp  = 1'b0;
				assign l_valid = 1'b0;
				assign l_prio  = '0;
				assign l_pay   = '0;
			end else begin : g_left
				assign l_disp  = cell_disp[gi-1];
				assign l_valid = cell_valid[gi-1];
				assign l_prio  = cell_prio[gi-1];
				assign l_pay   = cell_pay[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_right_end
				assign r_valid = 1'b0;
				assign r_prio  = '0;
				assign r_pay   = '0;
			end else begin : g_right
				assign r_valid = cell_valid[gi+1];
				assign r_prio  = cell_prio[gi+1];
				assign r_pay   = cell_pay[gi+1];
			end

			spq_cell #(
				.PAYLOAD_BITS (PAYLOAD_BITS),
				.HEAD         (gi == 0)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_prio    (cmd.priority_req),
				.new_pay     (new_pay),
				.left_disp   (l_disp),
				.left_valid  (l_valid),
				.left_prio   (l_prio),
				.left_pay    (l_pay),
				.right_valid (r_valid),
				.right_prio  (r_prio),
				.right_pay   (r_pay),
				.disp        (cell_disp[gi]),
				.valid       (cell_valid[gi]),
				.prio        (cell_prio[gi]),
				.pay         (cell_pay[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				if (cmd.opcode == OP_INSERT && full) begin
					status_q <= ST_FULL;
				end else if (cmd.opcode == OP_POP && empty) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_OK;
				end
			end
		end
	end

	// The head cell already holds the state after the step during the done cycle.
	always_comb begin
		res.status        = status_q;
		res.head_valid    = cell_valid[0];
		res.head_payload  = cell_valid[0] ? DATA_W'(cell_pay[0]) : '0;
		res.head_priority = cell_valid[0] ? cell_prio[0] : '0;
		res.entry_count   = COUNT_W'(count_q);
	end

	assign done = done_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !cell_valid[0])
		else $error("head occupancy disagrees with entry count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> (cell_prio[0] >= cell_prio[1]))
		else $error("head priority below second entry");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result beat");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_INSERT && full) |=> $stable(count_q))
		else $error("insert into full queue changed the count");

endmodule

`default_nettype wire

@@ tb/spq_order_checker.sv @@
`timescale 1ns / 100ps

module spq_order_checker import spq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     busy,
	input  wire spq_cmd_t cmd,
	input  wire logic     done,
	input  wire spq_res_t res,
	output int            fail_count,
	output int            pending
);

	logic signed [PRIO_W-1:0] slot_prio [DEPTH];
	logic [DATA_W-1:0]        slot_data [DEPTH];
	int                       fill = 0;
	spq_res_t                 head_expect_q [$];
	int                       err_count = 0;

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	function automatic spq_res_t apply_queue_cmd(input spq_cmd_t c);
		spq_res_t r;
		int       pos;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_INSERT: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// an entry equal to the head never overtakes it
					if (fill == 0 || $signed(c.priority_req) > $signed(slot_prio[0])) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < fill && $signed(slot_prio[pos]) > $signed(c.priority_req))
							pos++;
					end
					for (int k = fill; k > pos; k--) begin
						slot_prio[k] = slot_prio[k-1];
						slot_data[k] = slot_data[k-1];
					end
					slot_prio[pos] = c.priority_req;
					slot_data[pos] = c.payload;
					fill++;
				end
			end
			OP_POP: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int k = 0; k + 1 < fill; k++) begin
						slot_prio[k] = slot_prio[k+1];
						slot_data[k] = slot_data[k+1];
					end
					fill--;
				end
			end
			default: ;
		endcase
		if (fill > 0) begin
			r.head_valid    = 1'b1;
			r.head_payload  = slot_data[0];
			r.head_priority = slot_prio[0];
		end
		r.entry_count = COUNT_W'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spq_res_t want;
		if (!arst_n) begin
			fill = 0;
			head_expect_q.delete();
			pending    <= 0;
			fail_count <= err_count;
		end else begin
			// a result beat answers a command taken at an earlier edge
			if (done) begin
				if (head_expect_q.size() == 0) begin
					flag_mismatch("result beat with no command outstanding");
				end else begin
					want = head_expect_q.pop_front();
					if (res.status !== want.status)
						flag_mismatch($sformatf("status got %0d expected %0d",
							res.status, want.status));
					if (res.head_valid !== want.head_valid)
						flag_mismatch($sformatf("head_valid got %0b expected %0b",
							res.head_valid, want.head_valid));
					if (res.head_payload !== want.head_payload)
						flag_mismatch($sformatf("head_payload got %h expected %h",
							res.head_payload, want.head_payload));
					if (res.head_priority !== want.head_priority)
						flag_mismatch($sformatf("head_priority got %0d expected %0d",
							res.head_priority, want.head_priority));
					if (res.entry_count !== want.entry_count)
						flag_mismatch($sformatf("entry_count got %0d expected %0d",
							res.entry_count, want.entry_count));
				end
			end
			if (start && !busy)
				head_expect_q.push_back(apply_queue_cmd(cmd));
			pending    <= head_expect_q.size();
			fail_count <= err_count;
		end
	end

endmodule

@@ tb/sorted_priority_queue_core_tb.sv @@
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb import spq_pkg::*;;

	localparam int      IDLE_LIMIT = 2000;
	localparam int      RANDOM_PER_PHASE = 410;
	localparam spq_op_e OP_UNUSED = spq_op_e'(2'd3);
	localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	spq_cmd_t cmd;
	logic     done;
	spq_res_t res;
	int       fail_count;
	int       pending;
	int       gap_pct;
	int       idle_cycles = 0;

	sorted_priority_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	spq_order_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_priority_queue_core verification failed");
			$finish;
		end
	end

	task automatic issue(input spq_op_e op, input logic [DATA_W-1:0] data,
			input logic signed [PRIO_W-1:0] prio);
		spq_cmd_t c;
		c.opcode       = op;
		c.payload      = data;
		c.priority_req = prio;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		// idle each following cycle with the phase's share
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every outstanding result has come back
	task automatic drain_queue();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [PRIO_W-1:0] pick_priority();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 8) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: return PRIO_MAX;
					1: return PRIO_MIN;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random(input int count, input int pct);
		int insert_w;
		int r;
		gap_pct  = pct;
		insert_w = 50;
		for (int i = 0; i < count; i++) begin
			// drift the insert share so the queue swings between empty and full
			if (i % 32 == 0)
				insert_w = $urandom_range(15, 85);
			r = $urandom_range(0, 99);
			if (r < 3)
				issue(OP_UNUSED, $urandom, $urandom);
			else if (r < 12)
				issue(OP_TOP, $urandom, $urandom);
			else if (r < 12 + (88 * insert_w) / 100)
				issue(OP_INSERT, $urandom, pick_priority());
			else
				issue(OP_POP, $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		cmd         <= '0;
		gap_pct     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue
		issue(OP_TOP, 32'h0, 32'sh0);
		issue(OP_POP, 32'hFFFF_FFFF, PRIO_MAX);
		issue(OP_UNUSED, 32'hFFFF_FFFF, PRIO_MIN);
		// extremes and ties with the head
		issue(OP_INSERT, 32'h0000_0000, 32'sh0);
		issue(OP_INSERT, 32'hFFFF_FFFF, PRIO_MAX);
		issue(OP_INSERT, 32'h1234_5678, PRIO_MAX);
		issue(OP_INSERT, 32'hA5A5_A5A5, PRIO_MIN);
		issue(OP_INSERT, 32'h5A5A_5A5A, -32'sd1);
		issue(OP_INSERT, 32'h0F0F_0F0F, 32'sd1);
		issue(OP_INSERT, 32'hF0F0_F0F0, 32'sh0);
		for (int k = 0; k < 9; k++)
			issue(OP_INSERT, ~32'(k), 32'(k * 1000 - 4000));
		// full queue
		issue(OP_INSERT, 32'hDEAD_BEEF, PRIO_MAX);
		issue(OP_UNUSED, 32'h0, 32'sh0);
		issue(OP_TOP, 32'h0, 32'sh0);
		issue(OP_POP, 32'h0, 32'sh0);
		issue(OP_POP, 32'h0, 32'sh0);
		issue(OP_INSERT, 32'h8000_0001, PRIO_MIN);
		drain_queue();

		run_random(RANDOM_PER_PHASE, 21);
		drain_queue();
		run_random(RANDOM_PER_PHASE, 52);
		drain_queue();
		run_random(RANDOM_PER_PHASE, 0);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("sorted_priority_queue_core verification clean");
		else
			$display("sorted_priority_queue_core verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
tb/spq_order_checker.sv
tb/sorted_priority_queue_core_tb.sv
